// ===== hw/rtl/sliding_window_median_defines.svh =====
// assertion macros shared by the sliding window median rtl
// depends on nothing; included by files that carry assertions
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// property that must hold on every clock edge out of reset
`define SWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/swm_pkg.sv =====
// shared types and constants for the sliding window median block
// depends on nothing
package swm_pkg;

  localparam int unsigned SampleW = 15;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned MedW    = 16;
  localparam int unsigned SumW    = 64;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clear_step;   // clear one tree entry at the clear pointer
    logic load_item;    // latch sample, read old ring word
    logic upd_start;    // start a tree walk (remove or insert)
    logic upd_insert;   // 1 insert, 0 remove
    logic upd_step;     // one step (read or write phase) of a tree walk
    logic rank_start;   // start a descent
    logic rank_second;  // 1 second rank (even window)
    logic rank_step;    // one descent step
    logic finish;       // update sum and output registers
  } swm_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic upd_done;
    logic rank_done;
    logic clear_done;
    logic window_full;  // window holds k samples after this item
    logic was_full;     // window was full before this item
    logic k_even;
  } swm_sts_t;

endpackage

// ===== hw/rtl/swm_ram.sv =====
// generic single port ram with registered read
// depends on nothing
module swm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // read before write, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== hw/rtl/swm_datapath.sv =====
// datapath: ring buffer, count tree walks, order statistic descent, sum
// depends on swm_pkg and swm_ram
module swm_datapath #(
  parameter int unsigned WindowMax  = 4096,
  parameter int unsigned ValueCount = 32768
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [swm_pkg::CfgW-1:0]         window_size_i,
  input  logic                             cfg_we_i,
  input  logic [swm_pkg::SampleW-1:0]      sample_i,
  input  swm_pkg::swm_cmd_t                cmd_i,
  output swm_pkg::swm_sts_t                sts_o,
  output logic [swm_pkg::MedW-1:0]         median_twice_o,
  output logic [swm_pkg::SumW-1:0]         running_sum_twice_o,
  output logic                             sum_saturated_o
);
  import swm_pkg::*;

  localparam int unsigned TW  = $clog2(ValueCount + 1);  // tree index bits
  localparam int unsigned TD  = ValueCount + 1;
  localparam int unsigned RW  = (WindowMax > 1) ? $clog2(WindowMax) : 1;
  localparam int unsigned KW  = $clog2(WindowMax + 1);
  localparam int unsigned VW  = (ValueCount > 1) ? $clog2(ValueCount) : 1;
  localparam int unsigned CW  = $clog2(WindowMax + 1);  // counts up to k
  localparam int unsigned TopStep = 1 << (TW - 1);

  // effective window
  logic [KW-1:0] k;
  always_comb begin
    if (window_size_i == '0) k = KW'(1);
    else if (32'(window_size_i) > WindowMax) k = KW'(WindowMax);
    else k = KW'(window_size_i);
  end

  logic [RW-1:0] ptr_q;
  logic [KW-1:0] fill_q;
  logic [VW-1:0] v_q;
  logic          full_before_q;

  // saturated sample
  logic [VW-1:0] v_in;
  always_comb begin
    if (32'(sample_i) >= ValueCount) v_in = VW'(ValueCount - 1);
    else v_in = VW'(sample_i);
  end

  // ring ram
  logic [SampleW-1:0] ring_rdata;
  logic [RW-1:0]      ptr_use;
  assign ptr_use = (32'(ptr_q) >= 32'(k)) ? '0 : ptr_q;
  swm_ram #(.Width(SampleW), .Depth(1 << RW)) u_ring (
    .clk_i, .we_i(cmd_i.load_item), .addr_i(ptr_use),
    .wdata_i(SampleW'(v_in)), .rdata_o(ring_rdata)
  );

  // tree ram and walkers
  logic          t_we;
  logic [TW-1:0] t_addr;
  logic [CW-1:0] t_wdata, t_rdata;
  swm_ram #(.Width(CW), .Depth(TD)) u_tree (
    .clk_i, .we_i(t_we), .addr_i(t_addr), .wdata_i(t_wdata), .rdata_o(t_rdata)
  );

  logic [TW-1:0] clr_q;
  logic [TW:0]   ui_q;       // update index
  logic          uins_q;
  logic          uph_q;      // 0 read phase, 1 write phase
  logic [TW:0]   pos_q, step_q;
  logic [CW-1:0] rank_q;
  logic          rph_q;
  logic          rsec_q;     // descent for the second rank
  logic [VW-1:0] r1_q;
  logic [TW:0]   nxt;
  assign nxt = pos_q + step_q;

  always_comb begin
    t_we = 1'b0; t_addr = '0; t_wdata = '0;
    if (cmd_i.clear_step) begin
      t_we = 1'b1; t_addr = clr_q;
    end else if (cmd_i.upd_step) begin
      t_addr = TW'(ui_q);
      t_we = uph_q;
      t_wdata = uins_q ? t_rdata + 1'b1 : t_rdata - 1'b1;
    end else if (cmd_i.rank_step) begin
      t_addr = TW'(nxt);
    end
  end

  // descent result including the final step
  logic [TW:0]   pos_fin;
  logic [VW-1:0] rank_res;
  always_comb begin
    pos_fin = pos_q;
    if (32'(nxt) <= ValueCount && t_rdata < rank_q) pos_fin = nxt;
    if (32'(pos_fin) >= ValueCount) rank_res = VW'(ValueCount - 1);
    else rank_res = VW'(pos_fin);
  end

  // per item and walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0; fill_q <= '0; clr_q <= '0; ui_q <= '0; uph_q <= 1'b0;
      uins_q <= 1'b0; pos_q <= '0; step_q <= '0; rank_q <= '0; rph_q <= 1'b0;
      full_before_q <= 1'b0; v_q <= '0; r1_q <= '0; rsec_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ptr_q <= '0; fill_q <= '0; clr_q <= '0;
      end
      if (cmd_i.clear_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.load_item) begin
        v_q <= v_in;
        full_before_q <= (fill_q >= k);
        if (fill_q < k) fill_q <= fill_q + 1'b1;
        ptr_q <= (32'(ptr_use) + 1 >= 32'(k)) ? '0 : ptr_use + 1'b1;
      end
      if (cmd_i.upd_start) begin
        uins_q <= cmd_i.upd_insert;
        uph_q  <= 1'b0;
        ui_q   <= cmd_i.upd_insert ? (TW+1)'(v_q) + 1'b1
                                   : (TW+1)'(ring_rdata) + 1'b1;
      end else if (cmd_i.upd_step) begin
        uph_q <= ~uph_q;
        if (uph_q) ui_q <= ui_q + (ui_q & (~ui_q + 1'b1));
      end
      if (cmd_i.rank_start) begin
        pos_q <= '0; step_q <= (TW+1)'(TopStep); rph_q <= 1'b0;
        rsec_q <= cmd_i.rank_second;
        rank_q <= cmd_i.rank_second ? CW'((k >> 1) + 1'b1)
                 : (k[0] ? CW'((k + 1'b1) >> 1) : CW'(k >> 1));
      end else if (cmd_i.rank_step) begin
        rph_q <= ~rph_q;
        if (rph_q) begin
          if (32'(nxt) <= ValueCount && t_rdata < rank_q) begin
            pos_q <= nxt; rank_q <= rank_q - t_rdata;
          end
          step_q <= step_q >> 1;
        end
      end
      if (cmd_i.finish) r1_q <= '0;
      else if (cmd_i.rank_step && rph_q && step_q == (TW+1)'(1) && rsec_q) begin
        r1_q <= rank_res;
      end
    end
  end

  // sum and outputs
  logic [MedW:0]   m_full;
  logic [MedW-1:0] m;
  logic [SumW:0]   sum_new;
  logic [SumW-1:0] sum_q;
  logic            sat_q;
  logic [VW-1:0]   r_a_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.rank_step && rph_q && step_q == (TW+1)'(1) && !rsec_q)
      r_a_q <= rank_res;
  end
  assign m_full = k[0] ? {(MedW+1-VW)'(0), r_a_q} << 1
                       : (MedW+1)'(r_a_q) + (MedW+1)'(r1_q);
  assign m = (m_full > (MedW+1)'(16'hFFFF)) ? 16'hFFFF : MedW'(m_full);
  assign sum_new = (SumW+1)'(sum_q) + (SumW+1)'(m);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0; sat_q <= 1'b0; median_twice_o <= '0;
    end else if (cmd_i.finish) begin
      if (sum_new[SumW]) begin
        sum_q <= '1; sat_q <= 1'b1;
      end else sum_q <= SumW'(sum_new);
      median_twice_o <= m;
    end
  end
  assign running_sum_twice_o = sum_q;
  assign sum_saturated_o     = sat_q;

  assign sts_o.upd_done    = uph_q && (32'(ui_q + (ui_q & (~ui_q + 1'b1))) > ValueCount);
  assign sts_o.rank_done   = rph_q && step_q == (TW+1)'(1);
  assign sts_o.clear_done  = (32'(clr_q) == TD - 1);
  assign sts_o.window_full = (fill_q >= k);
  assign sts_o.was_full    = full_before_q;
  assign sts_o.k_even      = ~k[0];
endmodule

// ===== hw/rtl/swm_ctrl.sv =====
// controller state machine sequencing clear, tree walks and descents
// depends on swm_pkg and the assertion macro header
`include "sliding_window_median_defines.svh"
module swm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  output logic              cfg_ready_o,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  swm_pkg::swm_sts_t sts_i,
  output swm_pkg::swm_cmd_t cmd_o
);
  import swm_pkg::*;

  typedef enum logic [3:0] {
    StClear, StIdle, StLoad, StRem, StIns, StRankA, StRankB, StFin, StOut
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign cfg_ready_o = (state_q == StIdle);
  assign in_ready_o  = (state_q == StIdle) && !cfg_we_i;
  assign out_valid_o = out_valid_q;
  // output register free or being emptied this cycle
  assign out_free    = !out_valid_q || out_ready_i;

  // command decode
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      StClear: cmd_o.clear_step = 1'b1;
      StIdle:  cmd_o.load_item = in_valid_i && in_ready_o;
      StLoad:  begin
        cmd_o.upd_start  = 1'b1;
        cmd_o.upd_insert = !sts_i.was_full;
      end
      StRem:   begin
        cmd_o.upd_step = 1'b1;
        if (sts_i.upd_done) begin
          cmd_o.upd_start = 1'b1; cmd_o.upd_insert = 1'b1;
        end
      end
      StIns:   begin
        cmd_o.upd_step = 1'b1;
        if (sts_i.upd_done && sts_i.window_full) cmd_o.rank_start = 1'b1;
      end
      StRankA: begin
        cmd_o.rank_step = 1'b1;
        if (sts_i.rank_done && sts_i.k_even) begin
          cmd_o.rank_start = 1'b1; cmd_o.rank_second = 1'b1;
        end
      end
      StRankB: begin
        cmd_o.rank_step = 1'b1; cmd_o.rank_second = 1'b1;
      end
      StFin:   cmd_o.finish = out_free;
      StOut:   cmd_o = '0;
      default: cmd_o = '0;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear; out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StClear: if (sts_i.clear_done) state_q <= StIdle;
        StIdle:  begin
          if (cfg_we_i) state_q <= StClear;
          else if (in_valid_i) state_q <= StLoad;
        end
        StLoad:  state_q <= sts_i.was_full ? StRem : StIns;
        StRem:   if (sts_i.upd_done) state_q <= StIns;
        StIns:   if (sts_i.upd_done) state_q <= sts_i.window_full ? StRankA : StIdle;
        StRankA: if (sts_i.rank_done) state_q <= sts_i.k_even ? StRankB : StFin;
        StRankB: if (sts_i.rank_done) state_q <= StFin;
        StFin:   if (out_free) state_q <= StOut;
        StOut:   begin
          out_valid_q <= 1'b1; state_q <= StIdle;
        end
        default: state_q <= StClear;
      endcase
    end
  end

  `SWM_ASSERT(a_no_accept_busy, !(in_ready_o && state_q != StIdle), "ready while busy")
  `SWM_ASSERT_NEXT(a_fin_out, state_q == StFin && out_free, state_q == StOut, "finish not followed by output")
  `SWM_ASSERT(a_clear_no_ready, !(state_q == StClear && in_ready_o), "ready during clear")
endmodule

// ===== hw/rtl/sliding_window_median.sv =====
// Sliding window median, top level: joins controller and datapath.
// depends on swm_pkg, swm_ctrl, swm_datapath, swm_ram
//
// Input channel: one 15-bit sample word per valid/ready handshake.
// Config channel: one word writes window_size and restarts the window
// (count tree cleared, sum and saturation flag kept); taken only when idle.
// Output channel: one word per sample once the window is full: twice the
// median, the saturating running sum and its sticky flag.
// Each tree walk reads, then writes back, one count tree entry per visited
// level, 1 to 16 levels at the default size; a rank descent visits every
// level. A sample that only fills the window frees the input once its
// insertion walk is done. Otherwise load, a removal walk if the window was
// full, the insertion walk, one descent (odd window) or two (even window),
// finish and output run one after another, set by the single port of the
// count tree memory; the input is ready again as the output word appears.
// After reset and after each config write all VALUE_COUNT+1 tree entries
// are swept clear, one entry per cycle, with the input not ready.
// A stalled receiver holds the result; the next sample is still taken and
// worked on, and waits before its sum update until the old word has gone.
module sliding_window_median #(
  parameter int unsigned WINDOW_MAX  = 4096,
  parameter int unsigned VALUE_COUNT = 32768
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [swm_pkg::CfgW-1:0]     window_size_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [swm_pkg::SampleW-1:0]  sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [swm_pkg::MedW-1:0]     median_twice_o,
  output logic [swm_pkg::SumW-1:0]     running_sum_twice_o,
  output logic                         sum_saturated_o
);
  import swm_pkg::*;

  swm_cmd_t cmd;
  swm_sts_t sts;
  logic [CfgW-1:0] ws_q;
  logic cfg_we;

  // config register
  assign cfg_we = cfg_valid_i && cfg_ready_o;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ws_q <= CfgW'(10);
    else if (cfg_we) ws_q <= window_size_i;
  end

  swm_ctrl u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_ready_o, .in_valid_i, .in_ready_o,
    .out_valid_o, .out_ready_i, .sts_i(sts), .cmd_o(cmd)
  );

  swm_datapath #(.WindowMax(WINDOW_MAX), .ValueCount(VALUE_COUNT)) u_dp (
    .clk_i, .rst_ni, .window_size_i(ws_q), .cfg_we_i(cfg_we), .sample_i,
    .cmd_i(cmd), .sts_o(sts), .median_twice_o, .running_sum_twice_o,
    .sum_saturated_o
  );
endmodule
